// ===== hdl/epmd_pkg.sv =====
package epmd_pkg;

    localparam int GAIN_FRAC_BITS_DEF = 16;

    localparam int CNT_W  = 32;
    localparam int TGT_W  = 16;
    localparam int GAIN_W = 24;
    localparam int FS_W   = 31;
    localparam int DUTY_W = 8;
    localparam int POS_W  = 16;
    localparam int ERR_W  = 25;
    localparam int DIFF_W = 26;
    localparam int INTEG_W = 48;
    localparam int ACC_W  = 64;
    localparam int PROD_W = 58;
    localparam int IMAG_W = 73;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;

    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_LIMIT  = 3'd4;

    localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 24'd32768;
    localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = 24'd983;
    localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 24'd131072;
    localparam logic [FS_W-1:0]   FULL_SCALE_RST = 31'd1400;
    localparam logic [DUTY_W-1:0] DUTY_LIMIT_RST = 8'd150;

    // Position scale: count * 100 percent * 256 (Q.8).
    localparam logic [24:0] POS_SCALE = 25'd25600;

    localparam int DIV_STEPS = 16;
    localparam int DIV_CNT_W = 5;

    localparam int PC_W = 4;

    localparam logic [PC_W-1:0] ST_WAIT     = 4'd0;
    localparam logic [PC_W-1:0] ST_POS_MUL  = 4'd1;
    localparam logic [PC_W-1:0] ST_DIV_LOAD = 4'd2;
    localparam logic [PC_W-1:0] ST_DIV_STEP = 4'd3;
    localparam logic [PC_W-1:0] ST_ERR      = 4'd4;
    localparam logic [PC_W-1:0] ST_P_MUL    = 4'd5;
    localparam logic [PC_W-1:0] ST_D_MUL    = 4'd6;
    localparam logic [PC_W-1:0] ST_ILO_MUL  = 4'd7;
    localparam logic [PC_W-1:0] ST_IHI_MUL  = 4'd8;
    localparam logic [PC_W-1:0] ST_I_SUM    = 4'd9;
    localparam logic [PC_W-1:0] ST_I_ACC    = 4'd10;
    localparam logic [PC_W-1:0] ST_OUT      = 4'd11;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_POS,
        MUL_PROP,
        MUL_DERIV,
        MUL_INT_LO,
        MUL_INT_HI
    } t_mul_sel;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD,
        ACC_ADD_ITERM
    } t_acc_op;

    typedef enum logic [1:0] {
        IMAG_HOLD,
        IMAG_LOAD,
        IMAG_ADD_HI
    } t_imag_op;

    typedef enum logic [1:0] {
        COND_NONE,
        COND_NO_INPUT,
        COND_DIV_MORE,
        COND_OUT_BUSY
    } t_cond;

    typedef struct packed {
        t_cond           cond;
        logic [PC_W-1:0] tgt;
        logic            last;
        logic            in_load;
        t_mul_sel        mul_sel;
        logic            div_load;
        logic            div_step;
        logic            err_upd;
        t_acc_op         acc_op;
        t_imag_op        imag_op;
        logic            out_wr;
    } t_ctl;

    typedef struct packed {
        logic in_valid;
        logic div_more;
        logic out_busy;
    } t_seq_stat;

    function automatic t_ctl epmd_ucode(input logic [PC_W-1:0] pc);
        t_ctl w;
        w = '0;
        w.cond    = COND_NONE;
        w.mul_sel = MUL_NONE;
        w.acc_op  = ACC_HOLD;
        w.imag_op = IMAG_HOLD;
        unique case (pc)
            ST_WAIT: begin
                w.cond    = COND_NO_INPUT;
                w.tgt     = ST_WAIT;
                w.in_load = 1'b1;
            end
            ST_POS_MUL:  w.mul_sel = MUL_POS;
            ST_DIV_LOAD: w.div_load = 1'b1;
            ST_DIV_STEP: begin
                w.cond     = COND_DIV_MORE;
                w.tgt      = ST_DIV_STEP;
                w.div_step = 1'b1;
            end
            ST_ERR:   w.err_upd = 1'b1;
            ST_P_MUL: w.mul_sel = MUL_PROP;
            ST_D_MUL: begin
                w.acc_op  = ACC_LOAD;
                w.mul_sel = MUL_DERIV;
            end
            ST_ILO_MUL: begin
                w.acc_op  = ACC_ADD;
                w.mul_sel = MUL_INT_LO;
            end
            ST_IHI_MUL: begin
                w.imag_op = IMAG_LOAD;
                w.mul_sel = MUL_INT_HI;
            end
            ST_I_SUM: w.imag_op = IMAG_ADD_HI;
            ST_I_ACC: w.acc_op  = ACC_ADD_ITERM;
            ST_OUT: begin
                w.cond   = COND_OUT_BUSY;
                w.tgt    = ST_OUT;
                w.out_wr = 1'b1;
                w.last   = 1'b1;
            end
            default: w.last = 1'b1;
        endcase
        return w;
    endfunction

endpackage

// ===== hdl/epmd_sequencer.sv =====
module epmd_sequencer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  epmd_pkg::t_seq_stat i_stat,
    output epmd_pkg::t_ctl     o_ctl
);
    import epmd_pkg::*;

    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    t_ctl            ctl;
    logic            hit;

    always_comb begin
        ctl = epmd_ucode(r_pc);
        unique case (ctl.cond)
            COND_NO_INPUT: hit = !i_stat.in_valid;
            COND_DIV_MORE: hit = i_stat.div_more;
            COND_OUT_BUSY: hit = i_stat.out_busy;
            default:       hit = 1'b0;
        endcase
        if (hit) begin
            n_pc = ctl.tgt;
        end else if (ctl.last) begin
            n_pc = ST_WAIT;
        end else begin
            n_pc = r_pc + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= ST_WAIT;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_ctl = ctl;

endmodule

// ===== hdl/epmd_datapath.sv =====
module epmd_datapath #(
    parameter int GAIN_FRAC_BITS = epmd_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  epmd_pkg::t_ctl                i_ctl,
    input  logic                          i_in_valid,
    input  logic [epmd_pkg::CNT_W-1:0]    i_count,
    input  logic [epmd_pkg::TGT_W-1:0]    i_tgt,
    input  logic [epmd_pkg::GAIN_W-1:0]   i_prop_gain,
    input  logic [epmd_pkg::GAIN_W-1:0]   i_integ_gain,
    input  logic [epmd_pkg::GAIN_W-1:0]   i_deriv_gain,
    input  logic [epmd_pkg::FS_W-1:0]     i_full_scale,
    input  logic [epmd_pkg::DUTY_W-1:0]   i_duty_limit,
    output logic                          o_div_more,
    output logic                          o_forward,
    output logic [epmd_pkg::DUTY_W-1:0]   o_duty
);
    import epmd_pkg::*;

    localparam int SHIFT = 8 + GAIN_FRAC_BITS;
    localparam logic [IMAG_W-1:0] TERM_SAT = IMAG_W'(1) << 61;

    logic [CNT_W-1:0]          r_count;
    logic signed [TGT_W-1:0]   r_tgt;
    logic [31:0]               r_rem;
    logic [POS_W-1:0]          r_quo;
    logic [DIV_CNT_W-1:0]      r_div_cnt;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [ERR_W-1:0]   r_err;
    logic signed [DIFF_W-1:0]  r_diff;
    logic signed [ERR_W-1:0]   r_last_err;
    logic signed [INTEG_W-1:0] r_integ;
    logic signed [ACC_W-1:0]   r_acc;
    logic [IMAG_W-1:0]         r_imag;

    logic [FS_W-1:0]           fs_eff;
    logic [CNT_W-1:0]          count_in;
    logic signed [32:0]        mul_a;
    logic signed [24:0]        mul_b;
    logic [INTEG_W-1:0]        integ_mag;
    logic [31:0]               div_shift;
    logic                      div_ge;
    logic signed [ERR_W-1:0]   err;
    logic signed [INTEG_W:0]   integ_sum;
    logic signed [INTEG_W-1:0] integ_sat;
    logic [61:0]               imag_sat;
    logic [ACC_W-1:0]          iterm;
    logic [ACC_W-1:0]          acc_mag;
    logic [ACC_W-1:0]          acc_shr;

    always_comb begin
        fs_eff   = (i_full_scale == '0) ? FS_W'(1) : i_full_scale;
        count_in = (i_count > {fs_eff, 1'b0}) ? '0 : i_count;

        integ_mag = r_integ[INTEG_W-1] ? (INTEG_W'(0) - r_integ) : r_integ;

        case (i_ctl.mul_sel)
            MUL_POS: begin
                mul_a = {1'b0, r_count};
                mul_b = POS_SCALE;
            end
            MUL_PROP: begin
                mul_a = 33'(r_err);
                mul_b = {1'b0, i_prop_gain};
            end
            MUL_DERIV: begin
                mul_a = 33'(r_diff);
                mul_b = {1'b0, i_deriv_gain};
            end
            MUL_INT_LO: begin
                mul_a = {9'd0, integ_mag[23:0]};
                mul_b = {1'b0, i_integ_gain};
            end
            MUL_INT_HI: begin
                mul_a = {9'd0, integ_mag[47:24]};
                mul_b = {1'b0, i_integ_gain};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase

        // Remainder stays below the full scale, so its top bit is always clear.
        div_shift = {r_rem[30:0], r_quo[POS_W-1]};
        div_ge    = div_shift >= {1'b0, fs_eff};

        err = {{1{r_tgt[TGT_W-1]}}, r_tgt, 8'd0} - {9'd0, r_quo};

        integ_sum = {r_integ[INTEG_W-1], r_integ}
                  + {{(INTEG_W+1-ERR_W){err[ERR_W-1]}}, err};
        if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
            integ_sat = integ_sum[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                           : {1'b0, {(INTEG_W-1){1'b1}}};
        end else begin
            integ_sat = integ_sum[INTEG_W-1:0];
        end

        imag_sat = (r_imag > TERM_SAT) ? TERM_SAT[61:0] : r_imag[61:0];
        iterm    = {2'b00, imag_sat};

        acc_mag = r_acc[ACC_W-1] ? (ACC_W'(0) - r_acc) : r_acc;
        acc_shr = acc_mag >> SHIFT;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.in_load && i_in_valid) begin
            r_count <= count_in;
            r_tgt   <= i_tgt;
        end
        if (i_ctl.mul_sel != MUL_NONE) begin
            r_prod <= mul_a * mul_b;
        end
        if (i_ctl.div_load) begin
            r_rem <= {1'b0, r_prod[46:16]};
            r_quo <= r_prod[15:0];
        end else if (i_ctl.div_step) begin
            r_rem <= div_ge ? (div_shift - {1'b0, fs_eff}) : div_shift;
            r_quo <= {r_quo[POS_W-2:0], div_ge};
        end
        if (i_ctl.err_upd) begin
            r_err  <= err;
            r_diff <= DIFF_W'(r_last_err) - DIFF_W'(err);
        end
        case (i_ctl.acc_op)
            ACC_LOAD:      r_acc <= ACC_W'(r_prod);
            ACC_ADD:       r_acc <= r_acc + ACC_W'(r_prod);
            ACC_ADD_ITERM: r_acc <= r_integ[INTEG_W-1] ? (r_acc - iterm) : (r_acc + iterm);
            default:       r_acc <= r_acc;
        endcase
        case (i_ctl.imag_op)
            IMAG_LOAD:   r_imag <= {25'd0, r_prod[47:0]};
            IMAG_ADD_HI: r_imag <= r_imag + {1'b0, r_prod[47:0], 24'd0};
            default:     r_imag <= r_imag;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_cnt  <= '0;
            r_integ    <= '0;
            r_last_err <= '0;
        end else begin
            if (i_ctl.div_load) begin
                r_div_cnt <= DIV_CNT_W'(DIV_STEPS);
            end else if (i_ctl.div_step) begin
                r_div_cnt <= r_div_cnt - 1'b1;
            end
            if (i_ctl.err_upd) begin
                r_integ    <= integ_sat;
                r_last_err <= err;
            end
        end
    end

    assign o_div_more = (r_div_cnt != DIV_CNT_W'(1));
    assign o_forward  = !r_acc[ACC_W-1];
    assign o_duty     = (acc_shr > {{(ACC_W-DUTY_W){1'b0}}, i_duty_limit})
                      ? i_duty_limit : acc_shr[DUTY_W-1:0];

endmodule

// ===== hdl/encoder_pid_motor_drive.sv =====
// Channel  | Direction | Beat contents (lowest bit up)
// s        | in        | tdata: encoder_count[31:0], target_percent[47:32]
// m        | out       | tdata: forward[0], duty[8:1], zero fill[15:9]
// cfg      | in        | index 0..4 selects the register, data in low bits
//
// Each beat runs one tick: it is taken at the first program word and the result is
// registered from the last. The tick runs a 16-step restoring divider for the
// position and five passes through one shared 33x25 multiplier, all from a
// 12-word control program.
// A new beat is taken only while the program waits at its first word.
// A result that is not taken holds the program at its last word.
// Reset clears the program counter, integral and last error, and restores the
// register defaults.
module encoder_pid_motor_drive #(
    parameter int GAIN_FRAC_BITS = epmd_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    input  logic [47:0]                          i_s_tdata,  // encoder_count, target_percent
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    output logic [15:0]                          o_m_tdata,  // forward, duty
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [epmd_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [epmd_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import epmd_pkg::*;

    logic [GAIN_W-1:0] r_prop_gain;
    logic [GAIN_W-1:0] r_integ_gain;
    logic [GAIN_W-1:0] r_deriv_gain;
    logic [FS_W-1:0]   r_full_scale;
    logic [DUTY_W-1:0] r_duty_limit;

    logic              r_out_valid;
    logic              r_forward;
    logic [DUTY_W-1:0] r_duty;

    t_ctl              ctl;
    t_seq_stat         stat;
    logic              div_more;
    logic              dp_forward;
    logic [DUTY_W-1:0] dp_duty;
    logic              out_busy;
    logic              out_load;

    assign out_busy      = r_out_valid && !i_m_tready;
    assign out_load      = ctl.out_wr && !out_busy;
    assign stat.in_valid = i_s_tvalid;
    assign stat.div_more = div_more;
    assign stat.out_busy = out_busy;

    epmd_sequencer u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_ctl   (ctl)
    );

    epmd_datapath #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (ctl),
        .i_in_valid   (i_s_tvalid),
        .i_count      (i_s_tdata[31:0]),
        .i_tgt        (i_s_tdata[47:32]),
        .i_prop_gain  (r_prop_gain),
        .i_integ_gain (r_integ_gain),
        .i_deriv_gain (r_deriv_gain),
        .i_full_scale (r_full_scale),
        .i_duty_limit (r_duty_limit),
        .o_div_more   (div_more),
        .o_forward    (dp_forward),
        .o_duty       (dp_duty)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain  <= PROP_GAIN_RST;
            r_integ_gain <= INTEG_GAIN_RST;
            r_deriv_gain <= DERIV_GAIN_RST;
            r_full_scale <= FULL_SCALE_RST;
            r_duty_limit <= DUTY_LIMIT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PROP_GAIN:  r_prop_gain  <= i_cfg_data[GAIN_W-1:0];
                CFG_INTEG_GAIN: r_integ_gain <= i_cfg_data[GAIN_W-1:0];
                CFG_DERIV_GAIN: r_deriv_gain <= i_cfg_data[GAIN_W-1:0];
                CFG_FULL_SCALE: r_full_scale <= i_cfg_data[FS_W-1:0];
                CFG_DUTY_LIMIT: r_duty_limit <= i_cfg_data[DUTY_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_forward <= dp_forward;
            r_duty    <= dp_duty;
        end
    end

    assign o_s_tready  = ctl.in_load;
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = {7'd0, r_duty, r_forward};

endmodule

// ===== hdl/epmd_checker.sv =====
module epmd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] o_m_tdata
);

    // Each tick runs the whole program, so input is never taken twice in a row.
    a_no_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input accepted in two consecutive cycles");

    // A result cannot be produced in the cycle right after an input beat.
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !$rose(o_m_tvalid))
        else $error("result appeared right after an input beat");

    // A new result comes only from the last program word, never while waiting.
    a_result_not_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(!o_s_tready))
        else $error("result appeared while waiting for input");

    // The padding above the duty field stays zero.
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[15:9] == 7'd0))
        else $error("output padding bits not zero");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("stalled result beat changed");

endmodule

bind encoder_pid_motor_drive epmd_checker u_epmd_checker (.*);

// ===== test/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import epmd_pkg::*;

    localparam int     DUTY_SHIFT  = 8 + GAIN_FRAC_BITS_DEF;
    localparam longint INTEG_HI    = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint INTEG_LO    = -INTEG_HI - 1;
    localparam longint unsigned TERM_CAP = 64'h2000_0000_0000_0000;
    localparam int     HOLD_CYCLES = 300;

    typedef struct packed {
        logic       fwd;
        logic [7:0] duty;
    } t_drive;

    logic i_clk;
    logic i_rst_n = 1'b0;

    logic                  s_valid   = 1'b0;
    logic [47:0]           s_data    = '0;
    logic                  m_ready   = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_PROP_GAIN;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    wire        o_s_tready;
    wire        o_m_tvalid;
    wire [15:0] o_m_tdata;
    wire        o_cfg_ready;

    encoder_pid_motor_drive uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_valid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (s_data),     // encoder_count[31:0], target_percent[47:32]
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (m_ready),
        .o_m_tdata   (o_m_tdata),  // forward[0], duty[8:1], zero fill[15:9]
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // Controller state and registers as the block should hold them.
    logic [GAIN_W-1:0] kp         = PROP_GAIN_RST;
    logic [GAIN_W-1:0] ki         = INTEG_GAIN_RST;
    logic [GAIN_W-1:0] kd         = DERIV_GAIN_RST;
    logic [FS_W-1:0]   full_scale = FULL_SCALE_RST;
    logic [DUTY_W-1:0] duty_max   = DUTY_LIMIT_RST;
    longint            integ_acc  = 0;
    longint            prev_err   = 0;

    logic [47:0] tick_q[$];
    t_drive      drive_q[$];

    int  mismatch_cnt = 0;
    int  result_cnt   = 0;
    bit  no_gaps      = 1'b0;
    bit  hold_arm     = 1'b0;
    int  hold_cnt     = 0;
    wire rx_hold      = hold_arm && (hold_cnt < HOLD_CYCLES);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #30_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("tb_top: mismatch at %0t: %s", $realtime, msg);
        mismatch_cnt++;
    endtask

    function automatic void set_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_PROP_GAIN:  kp         = val[GAIN_W-1:0];
            CFG_INTEG_GAIN: ki         = val[GAIN_W-1:0];
            CFG_DERIV_GAIN: kd         = val[GAIN_W-1:0];
            CFG_FULL_SCALE: full_scale = val[FS_W-1:0];
            CFG_DUTY_LIMIT: duty_max   = val[DUTY_W-1:0];
            default: ;
        endcase
    endfunction

    // One control tick: position, error, integral, PID sum, direction and duty.
    function automatic t_drive pid_tick(input logic [31:0] count,
                                        input logic signed [15:0] tgt);
        longint unsigned cnt, fs, imag, mag;
        longint          pos, err, diff, iterm, u;
        t_drive          r;
        fs  = (full_scale == 0) ? 64'd1 : 64'(full_scale);
        cnt = 64'(count);
        if (cnt > 2 * fs)
            cnt = 0;
        pos = longint'((cnt * 64'd25600) / fs);
        err = longint'(tgt) * 256 - pos;

        integ_acc = integ_acc + err;
        if (integ_acc > INTEG_HI)
            integ_acc = INTEG_HI;
        if (integ_acc < INTEG_LO)
            integ_acc = INTEG_LO;

        diff     = prev_err - err;
        prev_err = err;

        imag = (integ_acc < 0) ? -integ_acc : integ_acc;
        // Past this bound the integral term dominates, so it is capped.
        if (ki != 0 && imag > TERM_CAP / 64'(ki))
            imag = TERM_CAP;
        else
            imag = imag * 64'(ki);
        iterm = (integ_acc < 0) ? -longint'(imag) : longint'(imag);

        u   = err * longint'(kp) + iterm + diff * longint'(kd);
        mag = (u < 0) ? -u : u;
        mag = mag >> DUTY_SHIFT;
        if (mag > 64'(duty_max))
            mag = 64'(duty_max);
        r.fwd  = (u >= 0);
        r.duty = mag[7:0];
        return r;
    endfunction

    // Input beat driver.
    always @(posedge i_clk) begin : tick_driver
        logic nxt_valid;
        nxt_valid = s_valid;
        if (!i_rst_n) begin
            nxt_valid = 1'b0;
        end else begin
            if (s_valid && o_s_tready) begin
                drive_q.push_back(pid_tick(s_data[31:0], s_data[47:32]));
                nxt_valid = 1'b0;
            end
            if (!nxt_valid && tick_q.size() != 0 && (no_gaps || $urandom_range(99) >= 19)) begin
                s_data <= tick_q.pop_front();
                nxt_valid = 1'b1;
            end
        end
        s_valid <= nxt_valid;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n)
            hold_cnt <= 0;
        else if (rx_hold)
            hold_cnt <= hold_cnt + 1;
    end

    // Result beat monitor.
    always @(posedge i_clk) begin : drive_monitor
        t_drive want;
        if (!i_rst_n) begin
            m_ready <= 1'b0;
        end else begin
            if (o_m_tvalid && m_ready) begin
                if (drive_q.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with none pending",
                                              result_cnt));
                end else begin
                    want = drive_q.pop_front();
                    if (o_m_tdata[0] !== want.fwd)
                        report_mismatch($sformatf("result %0d: forward %b, expected %b",
                                                  result_cnt, o_m_tdata[0], want.fwd));
                    if (o_m_tdata[8:1] !== want.duty)
                        report_mismatch($sformatf("result %0d: duty %0d, expected %0d",
                                                  result_cnt, o_m_tdata[8:1], want.duty));
                end
                result_cnt++;
            end
            m_ready <= !rx_hold && (no_gaps || $urandom_range(99) >= 19);
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        set_reg(idx, val);
    endtask

    task automatic load_regs(input logic [30:0] p, input logic [30:0] i,
                             input logic [30:0] d, input logic [30:0] fs,
                             input logic [30:0] lim);
        write_reg(CFG_PROP_GAIN, p);
        write_reg(CFG_INTEG_GAIN, i);
        write_reg(CFG_DERIV_GAIN, d);
        write_reg(CFG_FULL_SCALE, fs);
        write_reg(CFG_DUTY_LIMIT, lim);
    endtask

    task automatic push_tick(input logic [31:0] count, input logic [15:0] tgt);
        tick_q.push_back({tgt, count});
    endtask

    // Mostly counts inside the valid span and targets near the working range.
    function automatic logic [47:0] rand_tick();
        logic [31:0] span, cnt;
        logic [15:0] tgt;
        int unsigned pick;
        span = (full_scale == 0) ? 32'd2 : {full_scale, 1'b0};
        pick = $urandom_range(99);
        cnt  = $urandom;
        tgt  = 16'($urandom);
        if (pick < 80) begin
            cnt = $urandom_range(span, 0);
            tgt = 16'($urandom_range(200) - 50);
        end else if (pick < 90) begin
            cnt = span + 32'd1 + $urandom_range(3);
        end
        return {tgt, cnt};
    endfunction

    // Drain: nothing queued, nothing offered, nothing outstanding.
    task automatic wait_idle();
        do @(negedge i_clk);
        while (tick_q.size() != 0 || s_valid || drive_q.size() != 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic run_random(input int n);
        repeat (n) tick_q.push_back(rand_tick());
        wait_idle();
    endtask

    initial begin : stimulus
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings; the first tick gives zero control.
        push_tick(32'd0, 16'd0);
        push_tick(32'd2800, 16'd0);
        push_tick(32'd2801, 16'd0);
        push_tick(32'hFFFF_FFFF, 16'd0);
        push_tick(32'd1400, 16'd100);
        push_tick(32'd1400, 16'd100);
        push_tick(32'd0, 16'h7FFF);
        push_tick(32'd0, 16'h8000);
        push_tick(32'd700, 16'hFFFF);
        push_tick(32'd1399, 16'd1);
        push_tick(32'd0, 16'd150);
        push_tick(32'd1400, 16'hFF6A);
        push_tick(32'hAAAA_AAAA, 16'h5555);
        push_tick(32'h5555_5555, 16'hAAAA);
        push_tick(32'd700, 16'd50);
        push_tick(32'd700, 16'd50);
        wait_idle();

        // The receiver holds off while the sender keeps offering.
        repeat (300) tick_q.push_back(rand_tick());
        @(negedge i_clk);
        hold_arm = 1'b1;
        wait_idle();

        load_regs(31'hFF_FFFF, 31'd0, 31'd0, 31'd1, 31'd255);
        push_tick(32'd2, 16'd0);
        push_tick(32'd3, 16'd0);
        push_tick(32'd1, 16'd1);
        push_tick(32'hFFFF_FFFF, 16'hFFFF);
        run_random(150);

        load_regs(31'd0, 31'hFF_FFFF, 31'hFF_FFFF, 31'h7FFF_FFFF, 31'd0);
        push_tick(32'hFFFF_FFFE, 16'd200);
        push_tick(32'hFFFF_FFFF, 16'd200);
        run_random(100);

        for (int k = 0; k < 5; k++) begin
            if (k == 0)
                load_regs(31'($urandom), 31'($urandom), 31'($urandom), 31'($urandom),
                          31'($urandom));
            else
                load_regs(31'($urandom) >> $urandom_range(16, 7),
                          31'($urandom) >> $urandom_range(20, 10),
                          31'($urandom) >> $urandom_range(16, 7),
                          31'($urandom_range(20000, 1)), 31'($urandom_range(255)));
            run_random(120);
        end

        // A zero full scale acts as one.
        load_regs(31'd32768, 31'd983, 31'd131072, 31'd0, 31'd150);
        push_tick(32'd0, 16'd50);
        push_tick(32'd1, 16'd50);
        push_tick(32'd2, 16'd50);
        push_tick(32'd3, 16'd50);
        push_tick(32'hFFFF_FFFF, 16'd50);
        run_random(40);

        // Long stretch with no idling under a strong integral gain: the integral winds up.
        load_regs(31'($urandom_range(24'hFF_FFFF)), 31'hFF_FFFF, 31'd131072, 31'd1400,
                  31'd255);
        @(negedge i_clk);
        no_gaps = 1'b1;
        for (int n = 0; n < 100; n++) begin
            if ($urandom_range(99) < 5)
                tick_q.push_back(rand_tick());
            else
                push_tick(32'd0, 16'h8000);
        end
        wait_idle();

        repeat (40) @(posedge i_clk);
        if (drive_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", drive_q.size()));
        if (mismatch_cnt == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

// ===== encoder_pid_motor_drive.f =====
hdl/epmd_pkg.sv
hdl/epmd_sequencer.sv
hdl/epmd_datapath.sv
hdl/encoder_pid_motor_drive.sv
hdl/epmd_checker.sv
test/tb_top.sv
